### rtl/att_pkg.sv
// Shared constants, codes and state type of the aircraft track table.
`timescale 1ns / 1ps
package att_pkg;

  localparam int unsigned DefTableEntries  = 128;
  localparam int unsigned DefHistoryPoints = 32;

  localparam logic [31:0] TimeoutReset = 32'd60000;
  localparam logic [31:0] MaxAgeReset  = 32'd300000;
  localparam logic [39:0] MinMoveReset = 40'd7036874;

  localparam logic [2:0] StatusUpdated = 3'd0;
  localparam logic [2:0] StatusNew     = 3'd1;
  localparam logic [2:0] StatusFull    = 3'd2;
  localparam logic [2:0] StatusHit     = 3'd3;
  localparam logic [2:0] StatusMiss    = 3'd4;

  localparam logic OpRecord = 1'b0;
  localparam logic OpQuery  = 1'b1;

  localparam logic [1:0] CfgTimeout = 2'd0;
  localparam logic [1:0] CfgMaxAge  = 2'd1;
  localparam logic [1:0] CfgMinMove = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MOVE,
    S_MOVE_WB,
    S_SCAN_END,
    S_INS_CHK,
    S_PR_RD,
    S_PR_CHK,
    S_PR_END,
    S_LAST_CHK,
    S_SQ_A,
    S_SQ_B,
    S_CMP,
    S_FIN,
    S_Q_OUT
  } att_state_e;

endpackage

### rtl/att_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module att_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/aircraft_track_table_top.sv
// Top level of the aircraft track table: control sequencer around two memories.
//
// Usage: an item is taken on a clock edge with start high and busy low. op 0
// records a position for aircraft_key at now_ms; op 1 queries one history
// point. Exactly one result beat follows per item, shown for one cycle with
// done_o high; the receiver cannot stall, so it must take the beat then.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the
// user must write it only while busy is low, which the block itself does not
// enforce. Index 0 is the entry timeout, 1 the point age, 2 the minimum
// squared move, other indexes are ignored.
// Every item walks the entry memory, reading each live entry; a record evicts
// entries past the timeout, moving the last entry into the slot of an evicted
// one. A record then prunes points older than the point age, compares the
// squared move from the last kept point, if any, with the minimum and writes
// the entry back; a query reads the requested history point.
// Reset empties the table at once and loads the register defaults; the
// memories need no clearing, as entries are only read once written.
`timescale 1ns / 1ps
module aircraft_track_table_top #(
  parameter int unsigned TABLE_ENTRIES  = att_pkg::DefTableEntries,
  parameter int unsigned HISTORY_POINTS = att_pkg::DefHistoryPoints
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [23:0]        aircraft_key_i,
  input  logic signed [30:0] lat_i,
  input  logic signed [31:0] lon_i,
  input  logic signed [16:0] altitude_ft_i,
  input  logic [31:0]        now_ms_i,
  input  logic [4:0]         point_index_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [39:0]        cfg_wdata_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [6:0]         slot_o,
  output logic [5:0]         point_count_o,
  output logic [31:0]        first_seen_ms_o,
  output logic signed [30:0] out_lat_o,
  output logic signed [31:0] out_lon_o,
  output logic signed [16:0] out_altitude_ft_o,
  output logic [31:0]        out_time_ms_o
);

  localparam int unsigned N      = TABLE_ENTRIES;
  localparam int unsigned P      = HISTORY_POINTS;
  localparam int unsigned BW     = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CNTW   = $clog2(N + 1);
  localparam int unsigned PW     = $clog2(P);
  localparam int unsigned CW     = $clog2(P + 1);
  localparam int unsigned SW     = CW + 1;
  localparam int unsigned QW     = (CW > 5) ? CW : 5;
  localparam int unsigned HDEPTH = N * (2 ** PW);
  localparam int unsigned HRA    = $clog2(HDEPTH);

  typedef struct packed {
    logic [23:0]   key;
    logic [31:0]   first;
    logic [31:0]   last;
    logic [CW-1:0] pts;
    logic [PW-1:0] head;
    logic [BW-1:0] bank;
  } entry_t;

  typedef struct packed {
    logic [30:0] lat;
    logic [31:0] lon;
    logic [16:0] alt;
    logic [31:0] tstamp;
  } hist_t;

  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(P)) begin
      s = s - SW'(P);
    end
    return PW'(s);
  endfunction

  att_pkg::att_state_e state_q, state_d;

  logic [31:0] timeout_q, max_age_q;
  logic [39:0] min_move_q;

  logic [CNTW-1:0] count_q, count_d, hwm_q, hwm_d, idx_q, idx_d, slot_q, slot_d;
  logic            found_q, found_d;
  logic            op_q, op_d;
  logic [23:0]     key_q, key_d;
  logic [30:0]     lat_q, lat_d;
  logic [31:0]     lon_q, lon_d;
  logic [16:0]     alt_q, alt_d;
  logic [31:0]     now_q, now_d;
  logic [4:0]      pidx_q, pidx_d;
  logic [31:0]     first_q, first_d;
  logic [CW-1:0]   pts_q, pts_d, pr_i_q, pr_i_d;
  logic [PW-1:0]   head_q, head_d;
  logic [BW-1:0]   bank_q, bank_d, cur_bank_q, cur_bank_d;
  logic [2:0]      status_q, status_d;
  logic [31:0]     abs_lat_q, abs_lat_d, abs_lon_q, abs_lon_d;
  logic [63:0]     sq_a_q, sq_a_d, sq_b_q, sq_b_d;

  logic        done_q, done_d;
  logic [2:0]  ostatus_q, ostatus_d;
  logic [6:0]  oslot_q, oslot_d;
  logic [5:0]  ocount_q, ocount_d;
  logic [31:0] ofirst_q, ofirst_d;
  logic [30:0] olat_q, olat_d;
  logic [31:0] olon_q, olon_d;
  logic [16:0] oalt_q, oalt_d;
  logic [31:0] otime_q, otime_d;

  logic          e_we;
  logic [BW-1:0] e_waddr, e_raddr;
  entry_t        e_wdata, e_rd;
  logic          h_we;
  logic [HRA-1:0] h_waddr, h_raddr;
  hist_t         h_wdata, h_rd;

  logic              evict;
  logic [CNTW-1:0]   last_idx;
  logic [PW-1:0]     head_pruned, last_phys;
  logic [CW-1:0]     pts_pruned;
  logic signed [32:0] dlat, dlon;
  logic [31:0]       mul_a;
  logic [63:0]       mul_p;
  logic [64:0]       move_sum;
  logic              move_big;

  att_ram #(.WIDTH($bits(entry_t)), .DEPTH(N)) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (e_we),
    .waddr_i(e_waddr),
    .wdata_i(e_wdata),
    .raddr_i(e_raddr),
    .rdata_o(e_rd)
  );

  att_ram #(.WIDTH($bits(hist_t)), .DEPTH(HDEPTH)) u_hist_ram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_waddr),
    .wdata_i(h_wdata),
    .raddr_i(h_raddr),
    .rdata_o(h_rd)
  );

  assign evict       = (op_q == att_pkg::OpRecord) && ((now_q - e_rd.last) > timeout_q);
  assign last_idx    = count_q - CNTW'(1);
  assign head_pruned = ((pts_q == '0) || (pr_i_q == pts_q)) ? '0 : phys(head_q, pr_i_q);
  assign pts_pruned  = pts_q - pr_i_q;
  assign last_phys   = phys(head_pruned, pts_pruned - CW'(1));
  assign dlat        = 33'($signed(lat_q)) - 33'($signed(h_rd.lat));
  assign dlon        = 33'($signed(lon_q)) - 33'($signed(h_rd.lon));
  assign mul_a       = (state_q == att_pkg::S_SQ_A) ? abs_lat_q : abs_lon_q;
  assign mul_p       = {32'd0, mul_a} * {32'd0, mul_a};
  assign move_sum    = 65'(sq_a_q) + 65'(sq_b_q);
  assign move_big    = move_sum > 65'(min_move_q);

  assign busy = (state_q != att_pkg::S_IDLE);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    hwm_d      = hwm_q;
    idx_d      = idx_q;
    slot_d     = slot_q;
    found_d    = found_q;
    op_d       = op_q;
    key_d      = key_q;
    lat_d      = lat_q;
    lon_d      = lon_q;
    alt_d      = alt_q;
    now_d      = now_q;
    pidx_d     = pidx_q;
    first_d    = first_q;
    pts_d      = pts_q;
    pr_i_d     = pr_i_q;
    head_d     = head_q;
    bank_d     = bank_q;
    cur_bank_d = cur_bank_q;
    status_d   = status_q;
    abs_lat_d  = abs_lat_q;
    abs_lon_d  = abs_lon_q;
    sq_a_d     = sq_a_q;
    sq_b_d     = sq_b_q;
    done_d     = 1'b0;
    ostatus_d  = ostatus_q;
    oslot_d    = oslot_q;
    ocount_d   = ocount_q;
    ofirst_d   = ofirst_q;
    olat_d     = olat_q;
    olon_d     = olon_q;
    oalt_d     = oalt_q;
    otime_d    = otime_q;
    e_we       = 1'b0;
    e_waddr    = BW'(idx_q);
    e_wdata    = '0;
    e_raddr    = BW'(idx_q);
    h_we       = 1'b0;
    h_waddr    = HRA'({bank_q, PW'(0)});
    h_wdata    = '{lat: lat_q, lon: lon_q, alt: alt_q, tstamp: now_q};
    h_raddr    = '0;

    case (state_q)
      att_pkg::S_IDLE: begin
        if (start) begin
          op_d    = op_i;
          key_d   = aircraft_key_i;
          lat_d   = lat_i;
          lon_d   = lon_i;
          alt_d   = altitude_ft_i;
          now_d   = now_ms_i;
          pidx_d  = point_index_i;
          idx_d   = '0;
          found_d = 1'b0;
          state_d = att_pkg::S_SCAN_RD;
        end
      end
      att_pkg::S_SCAN_RD: begin
        e_raddr = BW'(idx_q);
        state_d = (idx_q >= count_q) ? att_pkg::S_SCAN_END : att_pkg::S_SCAN_CHK;
      end
      att_pkg::S_SCAN_CHK: begin
        if (evict) begin
          cur_bank_d = e_rd.bank;
          if (idx_q == last_idx) begin
            count_d = last_idx;
            state_d = att_pkg::S_SCAN_RD;
          end else begin
            e_raddr = BW'(last_idx);
            state_d = att_pkg::S_MOVE;
          end
        end else begin
          if ((e_rd.key == key_q) && !found_q) begin
            found_d = 1'b1;
            slot_d  = idx_q;
            first_d = e_rd.first;
            pts_d   = e_rd.pts;
            head_d  = e_rd.head;
            bank_d  = e_rd.bank;
          end
          idx_d   = idx_q + CNTW'(1);
          state_d = att_pkg::S_SCAN_RD;
        end
      end
      att_pkg::S_MOVE: begin
        e_we    = 1'b1;
        e_waddr = BW'(idx_q);
        e_wdata = e_rd;
        state_d = att_pkg::S_MOVE_WB;
      end
      att_pkg::S_MOVE_WB: begin
        // The vacated last slot keeps the history bank of the evicted entry.
        e_we         = 1'b1;
        e_waddr      = BW'(last_idx);
        e_wdata.bank = cur_bank_q;
        count_d      = last_idx;
        state_d      = att_pkg::S_SCAN_RD;
      end
      att_pkg::S_SCAN_END: begin
        pr_i_d = '0;
        if (op_q == att_pkg::OpQuery) begin
          if (!found_q) begin
            done_d    = 1'b1;
            ostatus_d = att_pkg::StatusMiss;
            oslot_d   = '0;
            ocount_d  = '0;
            ofirst_d  = '0;
            olat_d    = '0;
            olon_d    = '0;
            oalt_d    = '0;
            otime_d   = '0;
            state_d   = att_pkg::S_IDLE;
          end else if (QW'(pidx_q) < QW'(pts_q)) begin
            h_raddr = HRA'({bank_q, phys(head_q, CW'(pidx_q))});
            state_d = att_pkg::S_Q_OUT;
          end else begin
            done_d    = 1'b1;
            ostatus_d = att_pkg::StatusMiss;
            oslot_d   = 7'(slot_q);
            ocount_d  = 6'(pts_q);
            ofirst_d  = first_q;
            olat_d    = '0;
            olon_d    = '0;
            oalt_d    = '0;
            otime_d   = '0;
            state_d   = att_pkg::S_IDLE;
          end
        end else if (found_q) begin
          status_d = att_pkg::StatusUpdated;
          state_d  = att_pkg::S_PR_RD;
        end else if (count_q < CNTW'(N)) begin
          status_d = att_pkg::StatusNew;
          slot_d   = count_q;
          count_d  = count_q + CNTW'(1);
          first_d  = now_q;
          pts_d    = '0;
          head_d   = '0;
          if (count_q < hwm_q) begin
            e_raddr = BW'(count_q);
            state_d = att_pkg::S_INS_CHK;
          end else begin
            bank_d  = BW'(count_q);
            hwm_d   = count_q + CNTW'(1);
            state_d = att_pkg::S_PR_RD;
          end
        end else begin
          done_d    = 1'b1;
          ostatus_d = att_pkg::StatusFull;
          oslot_d   = '0;
          ocount_d  = '0;
          ofirst_d  = '0;
          olat_d    = '0;
          olon_d    = '0;
          oalt_d    = '0;
          otime_d   = '0;
          state_d   = att_pkg::S_IDLE;
        end
      end
      att_pkg::S_INS_CHK: begin
        bank_d  = e_rd.bank;
        state_d = att_pkg::S_PR_RD;
      end
      att_pkg::S_PR_RD: begin
        h_raddr = HRA'({bank_q, phys(head_q, pr_i_q)});
        state_d = (pr_i_q >= pts_q) ? att_pkg::S_PR_END : att_pkg::S_PR_CHK;
      end
      att_pkg::S_PR_CHK: begin
        if ((now_q - h_rd.tstamp) <= max_age_q) begin
          state_d = att_pkg::S_PR_END;
        end else begin
          pr_i_d  = pr_i_q + CW'(1);
          state_d = att_pkg::S_PR_RD;
        end
      end
      att_pkg::S_PR_END: begin
        if (pts_pruned == '0) begin
          h_we    = 1'b1;
          h_waddr = HRA'({bank_q, PW'(0)});
          pts_d   = CW'(1);
          head_d  = '0;
          state_d = att_pkg::S_FIN;
        end else begin
          h_raddr = HRA'({bank_q, last_phys});
          pts_d   = pts_pruned;
          head_d  = head_pruned;
          state_d = att_pkg::S_LAST_CHK;
        end
      end
      att_pkg::S_LAST_CHK: begin
        abs_lat_d = dlat[32] ? 32'(-dlat) : 32'(dlat);
        abs_lon_d = dlon[32] ? 32'(-dlon) : 32'(dlon);
        state_d   = att_pkg::S_SQ_A;
      end
      att_pkg::S_SQ_A: begin
        sq_a_d  = mul_p;
        state_d = att_pkg::S_SQ_B;
      end
      att_pkg::S_SQ_B: begin
        sq_b_d  = mul_p;
        state_d = att_pkg::S_CMP;
      end
      att_pkg::S_CMP: begin
        if (move_big) begin
          h_we = 1'b1;
          if (pts_q < CW'(P)) begin
            h_waddr = HRA'({bank_q, phys(head_q, pts_q)});
            pts_d   = pts_q + CW'(1);
          end else begin
            h_waddr = HRA'({bank_q, head_q});
            head_d  = phys(head_q, CW'(1));
          end
        end
        state_d = att_pkg::S_FIN;
      end
      att_pkg::S_FIN: begin
        e_we      = 1'b1;
        e_waddr   = BW'(slot_q);
        e_wdata   = '{key: key_q, first: first_q, last: now_q, pts: pts_q,
                      head: head_q, bank: bank_q};
        done_d    = 1'b1;
        ostatus_d = status_q;
        oslot_d   = 7'(slot_q);
        ocount_d  = 6'(pts_q);
        ofirst_d  = first_q;
        olat_d    = '0;
        olon_d    = '0;
        oalt_d    = '0;
        otime_d   = '0;
        state_d   = att_pkg::S_IDLE;
      end
      att_pkg::S_Q_OUT: begin
        done_d    = 1'b1;
        ostatus_d = att_pkg::StatusHit;
        oslot_d   = 7'(slot_q);
        ocount_d  = 6'(pts_q);
        ofirst_d  = first_q;
        olat_d    = h_rd.lat;
        olon_d    = h_rd.lon;
        oalt_d    = h_rd.alt;
        otime_d   = h_rd.tstamp;
        state_d   = att_pkg::S_IDLE;
      end
      default: begin
        state_d = att_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= att_pkg::S_IDLE;
      count_q    <= '0;
      hwm_q      <= '0;
      done_q     <= 1'b0;
      timeout_q  <= att_pkg::TimeoutReset;
      max_age_q  <= att_pkg::MaxAgeReset;
      min_move_q <= att_pkg::MinMoveReset;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      hwm_q   <= hwm_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          att_pkg::CfgTimeout: timeout_q  <= cfg_wdata_i[31:0];
          att_pkg::CfgMaxAge:  max_age_q  <= cfg_wdata_i[31:0];
          att_pkg::CfgMinMove: min_move_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    slot_q     <= slot_d;
    found_q    <= found_d;
    op_q       <= op_d;
    key_q      <= key_d;
    lat_q      <= lat_d;
    lon_q      <= lon_d;
    alt_q      <= alt_d;
    now_q      <= now_d;
    pidx_q     <= pidx_d;
    first_q    <= first_d;
    pts_q      <= pts_d;
    pr_i_q     <= pr_i_d;
    head_q     <= head_d;
    bank_q     <= bank_d;
    cur_bank_q <= cur_bank_d;
    status_q   <= status_d;
    abs_lat_q  <= abs_lat_d;
    abs_lon_q  <= abs_lon_d;
    sq_a_q     <= sq_a_d;
    sq_b_q     <= sq_b_d;
    ostatus_q  <= ostatus_d;
    oslot_q    <= oslot_d;
    ocount_q   <= ocount_d;
    ofirst_q   <= ofirst_d;
    olat_q     <= olat_d;
    olon_q     <= olon_d;
    oalt_q     <= oalt_d;
    otime_q    <= otime_d;
  end

  assign done_o            = done_q;
  assign status_o          = ostatus_q;
  assign slot_o            = oslot_q;
  assign point_count_o     = ocount_q;
  assign first_seen_ms_o   = ofirst_q;
  assign out_lat_o         = $signed(olat_q);
  assign out_lon_o         = $signed(olon_q);
  assign out_altitude_ft_o = $signed(oalt_q);
  assign out_time_ms_o     = otime_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNTW'(N)) && (count_q <= hwm_q))
    else $error("Entry count exceeds the table or the bank high-water mark.");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == att_pkg::S_IDLE))
    else $error("Result beat shown while an item is still in progress.");

  a_fin_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == att_pkg::S_FIN) |-> ((pts_q != '0) && (pts_q <= CW'(P))))
    else $error("Entry written back with an impossible point count.");

  a_start_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> !done_q)
    else $error("Result beat appeared right after an item was taken.");

endmodule
